/* rtl/tlsf_heap_allocator_unit_defines.svh */
// Assertion macros for the heap allocator checker.
// Depends on a clk and an active-low rst_n in the scope of use.
`ifndef TLSF_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define TLSF_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, reset masked
`define TLSF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlsf check failed");

// Next-cycle implication, reset masked
`define TLSF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlsf check failed");

`endif

/* rtl/tlsf_pkg.sv */
// Shared types, status codes and class helpers for the TLSF allocator.
// No dependencies.
package tlsf_pkg;

  // result status codes
  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_IGN  = 2'd2;

  localparam int GRAIN     = 16;
  localparam int BLK_HDR   = 8;
  localparam int SPLIT_MIN = BLK_HDR + GRAIN;

  // size class: first level and second level
  typedef struct packed {
    logic [4:0] f;
    logic [2:0] s;
  } cls_t;

  // header store write enables
  typedef struct packed {
    logic size_we;
    logic next_we;
    logic prev_we;
  } hdr_we_t;

  // class store operations
  typedef struct packed {
    logic head_we;
    logic map_set;
    logic map_clr;
  } cls_op_t;

  function automatic logic [4:0] top_bit(logic [31:0] v);
    logic [4:0] m;
    m = 5'd0;
    for (int k = 0; k < 32; k++) begin
      if (v[k]) m = 5'(k);
    end
    return m;
  endfunction

  function automatic logic [4:0] low_bit(logic [31:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int k = 31; k >= 0; k--) begin
      if (v[k]) n = 5'(k);
    end
    return n;
  endfunction

  // highest set bit clamped to 3, next three bits; at the top level and above, clamps to fl-1 and 7
  function automatic cls_t classify(logic [31:0] v, int fl);
    cls_t c;
    logic [4:0] m;
    logic [31:0] sh;
    m = top_bit(v);
    if (m < 5'd3) m = 5'd3;
    sh = v >> (m - 5'd3);
    c.s = sh[2:0];
    if (int'(m) >= fl) begin
      m = 5'(fl - 1);
      c.s = 3'd7;
    end
    c.f = m;
    return c;
  endfunction

endpackage

/* rtl/tlsf_heap_allocator_unit.sv */
// TLSF heap allocator top level: request sequencer, counters, result register.
// Depends on tlsf_pkg, tlsf_hdr_store and tlsf_class_store.
//
//   channel | direction | ports
//   in      | input     | in_valid in_stall in_kind in_request_bytes in_release_addr
//   out     | output    | out_valid out_stall out_status out_granted_addr
//           |           |   out_bytes_in_use out_bytes_available
//   cfg     | input     | cfg_we cfg_wdata (heap_base)
//
// One transaction at a time, input to input. An allocate runs RND, FIND, HEAD, TAKE and,
// on a split, SPLIT, PUSH and LINK; a free runs FREE, FCHK, PUSH and LINK; all end in DONE.
// Each step waits on the registered read of the header or head memory before it writes back.
// After reset a clearing pass sweeps all HEAP_BYTES/16 entries of the header memory;
// in_stall stays high during it. A finished result waits in the output register
// while the next transaction is accepted; the sequencer holds only if it is still full.
module tlsf_heap_allocator_unit #(
  parameter int HEAP_BYTES   = 65536,
  parameter int FIRST_LEVELS = 19
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [16:0] in_request_bytes,
  input  logic [31:0] in_release_addr,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_addr,
  output logic [16:0] out_bytes_in_use,
  output logic [16:0] out_bytes_available,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import tlsf_pkg::*;

  localparam int NBLK   = HEAP_BYTES / 16;
  localparam int BW     = $clog2(NBLK);
  localparam int LW     = BW + 1;
  localparam int SW     = $clog2(HEAP_BYTES);
  localparam int CW     = SW + 1;
  localparam int NCLASS = FIRST_LEVELS * 8;
  localparam int CLW    = $clog2(NCLASS);
  localparam logic [LW-1:0] NONE = LW'(NBLK);
  localparam cls_t HCLS = classify(32'(HEAP_BYTES - 16), FIRST_LEVELS);
  localparam logic [SW-1:0] INIT_WORD = SW'(HEAP_BYTES - 16) | SW'(1);

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RND   = 4'd2;
  localparam logic [3:0] S_FIND  = 4'd3;
  localparam logic [3:0] S_HEAD  = 4'd4;
  localparam logic [3:0] S_TAKE  = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_PUSH  = 4'd9;
  localparam logic [3:0] S_LINK  = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [LW-1:0] clr_r, clr_nxt;
  logic [31:0]   base_r;
  logic          kind_r;
  logic [16:0]   req_r;
  logic [31:0]   addr_r;
  logic [17:0]   sz_r, sz_nxt;
  cls_t          qcls_r, qcls_nxt;
  cls_t          fcls_r, fcls_nxt;
  cls_t          tcls_r, tcls_nxt;
  logic [LW-1:0] h_r, h_nxt;
  logic [LW-1:0] tgt_r, tgt_nxt;
  logic [LW-1:0] hj_r, hj_nxt;
  logic [SW-1:0] rest_r, rest_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [31:0]   grant_r, grant_nxt;
  logic          out_valid_r;
  logic [1:0]    out_stat_r;
  logic [31:0]   out_grant_r;
  logic [16:0]   out_used_r, out_free_r;

  // memory ports
  hdr_we_t       hwe;
  logic [BW-1:0] h_raddr, size_waddr, next_waddr, prev_waddr;
  logic [SW-1:0] size_wdata, size_rdata;
  logic [LW-1:0] next_wdata, prev_wdata, next_rdata, prev_rdata;
  cls_op_t       cop;
  logic [CLW-1:0] head_raddr, head_waddr;
  logic [LW-1:0] head_wdata, head_rdata;
  cls_t          map_cls, find_cls;
  logic          find_ok;

  tlsf_hdr_store #(.HEAP_BYTES(HEAP_BYTES)) u_hdr (
    .clk        (clk),
    .we         (hwe),
    .raddr      (h_raddr),
    .size_waddr (size_waddr),
    .size_wdata (size_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .size_rdata (size_rdata),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata)
  );

  tlsf_class_store #(.HEAP_BYTES(HEAP_BYTES), .FIRST_LEVELS(FIRST_LEVELS)) u_cls (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (cop),
    .head_raddr (head_raddr),
    .head_waddr (head_waddr),
    .head_wdata (head_wdata),
    .head_rdata (head_rdata),
    .map_cls    (map_cls),
    .find_q     (qcls_r),
    .find_ok    (find_ok),
    .find_cls   (find_cls)
  );

  assign in_stall = (state_r != S_IDLE);
  wire in_take  = in_valid && !in_stall;
  wire out_free = !out_valid_r || !out_stall;

  // sequencer
  always_comb begin
    logic [7:0]  cidx;
    logic [31:0] sz32, r32, off, i32, j32;
    logic [4:0]  m;
    logic [SW-1:0] bs;
    logic [SW-1:0] rest;
    logic [SW-1:0] amt;
    logic          split;
    cls_t          c;

    state_nxt = state_r;
    clr_nxt   = clr_r;
    sz_nxt    = sz_r;
    qcls_nxt  = qcls_r;
    fcls_nxt  = fcls_r;
    tcls_nxt  = tcls_r;
    h_nxt     = h_r;
    tgt_nxt   = tgt_r;
    hj_nxt    = hj_r;
    rest_nxt  = rest_r;
    used_nxt  = used_r;
    free_nxt  = free_r;
    stat_nxt  = stat_r;
    grant_nxt = grant_r;

    hwe        = '0;
    h_raddr    = tgt_r[BW-1:0];
    size_waddr = tgt_r[BW-1:0];
    size_wdata = size_rdata;
    next_waddr = tgt_r[BW-1:0];
    next_wdata = NONE;
    prev_waddr = tgt_r[BW-1:0];
    prev_wdata = NONE;
    cop        = '0;
    cidx       = 8'(find_cls);
    head_raddr = cidx[CLW-1:0];
    head_waddr = cidx[CLW-1:0];
    head_wdata = NONE;
    map_cls    = fcls_r;

    sz32  = 32'((32'(req_r) + 32'(BLK_HDR + GRAIN - 1)) & ~32'(GRAIN - 1));
    m     = top_bit(sz32);
    r32   = sz32 + ((32'd1 << (m - 5'd3)) - 32'd1);
    off   = addr_r - base_r - 32'(GRAIN);
    i32   = off >> 4;
    bs    = size_rdata & ~SW'(GRAIN - 1);
    rest  = bs - SW'(sz_r);
    split = 32'(rest) >= 32'(SPLIT_MIN);
    amt   = split ? SW'(sz_r) : bs;
    j32   = 32'(h_r) + 32'(sz_r >> 4);
    c     = classify(32'(bs), FIRST_LEVELS);

    unique case (state_r)
      S_CLEAR: begin
        // sweep headers; seed block 0 and the heads
        hwe.size_we = 1'b1;
        size_waddr  = clr_r[BW-1:0];
        size_wdata  = (clr_r == '0) ? INIT_WORD : '0;
        hwe.next_we = (clr_r == '0);
        hwe.prev_we = (clr_r == '0);
        next_waddr  = '0;
        prev_waddr  = '0;
        cop.head_we = (32'(clr_r) < 32'(NCLASS));
        head_waddr  = clr_r[CLW-1:0];
        head_wdata  = (32'(clr_r) == 32'(8'(HCLS))) ? '0 : NONE;
        clr_nxt     = clr_r + LW'(1);
        if (clr_r == LW'(NBLK - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        stat_nxt  = STAT_IGN;
        grant_nxt = 32'd0;
        if (in_take) state_nxt = in_kind ? S_FREE : S_RND;
      end
      S_RND: begin
        // round up and take the class of the next class boundary
        sz_nxt   = sz32[17:0];
        qcls_nxt = classify(r32, FIRST_LEVELS);
        state_nxt = (req_r == 17'd0) ? S_DONE : S_FIND;
      end
      S_FIND: begin
        fcls_nxt = find_cls;
        if (find_ok) begin
          state_nxt = S_HEAD;
        end else begin
          stat_nxt  = STAT_OOM;
          state_nxt = S_DONE;
        end
      end
      S_HEAD: begin
        h_nxt   = head_rdata;
        h_raddr = head_rdata[BW-1:0];
        if (head_rdata >= NONE) begin
          stat_nxt  = STAT_OOM;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        if (32'(bs) < 32'(sz_r)) begin
          stat_nxt  = STAT_OOM;
          state_nxt = S_DONE;
        end else begin
          // unlink the head block
          cidx = 8'(fcls_r);
          head_waddr = cidx[CLW-1:0];
          head_wdata = next_rdata;
          cop.head_we = (prev_rdata >= NONE);
          hwe.next_we = (prev_rdata < NONE);
          next_waddr  = prev_rdata[BW-1:0];
          next_wdata  = next_rdata;
          hwe.prev_we = (next_rdata < NONE);
          prev_waddr  = next_rdata[BW-1:0];
          prev_wdata  = prev_rdata;
          cop.map_clr = (prev_rdata >= NONE) && (next_rdata >= NONE);
          map_cls     = fcls_r;
          // shrink to the request on a split, drop the free flag
          hwe.size_we = 1'b1;
          size_waddr  = h_r[BW-1:0];
          size_wdata  = amt;
          free_nxt    = free_r - CW'(amt);
          used_nxt    = used_r + CW'(amt);
          grant_nxt   = base_r + 32'(GRAIN) + (32'(h_r[BW-1:0]) << 4);
          stat_nxt    = STAT_DONE;
          rest_nxt    = rest;
          tgt_nxt     = j32[LW-1:0];
          state_nxt   = (split && j32 < 32'(NBLK)) ? S_SPLIT : S_DONE;
        end
      end
      S_SPLIT: begin
        // write the remainder header, fetch its class head
        hwe.size_we = 1'b1;
        size_wdata  = rest_r | SW'(1);
        tcls_nxt    = classify(32'(rest_r), FIRST_LEVELS);
        cidx        = 8'(tcls_nxt);
        head_raddr  = cidx[CLW-1:0];
        state_nxt   = S_PUSH;
      end
      S_FREE: begin
        tgt_nxt = i32[LW-1:0];
        h_raddr = i32[BW-1:0];
        if (addr_r != 32'd0 && off[3:0] == 4'd0 && i32 < 32'(NBLK)) begin
          state_nxt = S_FCHK;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FCHK: begin
        tcls_nxt   = c;
        cidx       = 8'(c);
        head_raddr = cidx[CLW-1:0];
        if (bs != '0 && !size_rdata[0]) begin
          used_nxt    = used_r - CW'(bs);
          free_nxt    = free_r + CW'(bs);
          hwe.size_we = 1'b1;
          size_wdata  = size_rdata | SW'(1);
          stat_nxt    = STAT_DONE;
          state_nxt   = S_PUSH;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_PUSH: begin
        // push the target block at its class head
        hj_nxt      = head_rdata;
        hwe.next_we = 1'b1;
        next_wdata  = head_rdata;
        hwe.prev_we = 1'b1;
        prev_wdata  = NONE;
        cidx        = 8'(tcls_r);
        head_waddr  = cidx[CLW-1:0];
        head_wdata  = tgt_r;
        cop.head_we = 1'b1;
        cop.map_set = 1'b1;
        map_cls     = tcls_r;
        state_nxt   = S_LINK;
      end
      S_LINK: begin
        hwe.prev_we = (hj_r < NONE);
        prev_waddr  = hj_r[BW-1:0];
        prev_wdata  = tgt_r;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      base_r  <= 32'd0;
      used_r  <= '0;
      free_r  <= CW'(HEAP_BYTES - 16);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      used_r  <= used_nxt;
      free_r  <= free_nxt;
      if (cfg_we) base_r <= cfg_wdata;
      if (state_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic [31:0] u32, f32;
    u32 = 32'(used_r);
    f32 = 32'(free_r);
    if (in_take) begin
      kind_r <= in_kind;
      req_r  <= in_request_bytes;
      addr_r <= in_release_addr;
    end
    sz_r    <= sz_nxt;
    qcls_r  <= qcls_nxt;
    fcls_r  <= fcls_nxt;
    tcls_r  <= tcls_nxt;
    h_r     <= h_nxt;
    tgt_r   <= tgt_nxt;
    hj_r    <= hj_nxt;
    rest_r  <= rest_nxt;
    stat_r  <= stat_nxt;
    grant_r <= grant_nxt;
    // load the result register
    if (state_r == S_DONE && out_free) begin
      out_stat_r  <= stat_r;
      out_grant_r <= (stat_r == STAT_DONE && !kind_r) ? grant_r : 32'd0;
      out_used_r  <= u32[16:0];
      out_free_r  <= f32[16:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_stat_r;
  assign out_granted_addr    = out_grant_r;
  assign out_bytes_in_use    = out_used_r;
  assign out_bytes_available = out_free_r;

endmodule

/* rtl/tlsf_hdr_store.sv */
// Block header store: size word, next link and prev link memories.
// Depends on tlsf_pkg.
module tlsf_hdr_store #(
  parameter int HEAP_BYTES = 65536
) (
  input  logic                                clk,
  input  tlsf_pkg::hdr_we_t                   we,
  input  logic [$clog2(HEAP_BYTES/16)-1:0]    raddr,
  input  logic [$clog2(HEAP_BYTES/16)-1:0]    size_waddr,
  input  logic [$clog2(HEAP_BYTES)-1:0]       size_wdata,
  input  logic [$clog2(HEAP_BYTES/16)-1:0]    next_waddr,
  input  logic [$clog2(HEAP_BYTES/16):0]      next_wdata,
  input  logic [$clog2(HEAP_BYTES/16)-1:0]    prev_waddr,
  input  logic [$clog2(HEAP_BYTES/16):0]      prev_wdata,
  output logic [$clog2(HEAP_BYTES)-1:0]       size_rdata,
  output logic [$clog2(HEAP_BYTES/16):0]      next_rdata,
  output logic [$clog2(HEAP_BYTES/16):0]      prev_rdata
);
  import tlsf_pkg::*;

  localparam int NBLK = HEAP_BYTES / 16;
  localparam int SW   = $clog2(HEAP_BYTES);
  localparam int LW   = $clog2(NBLK) + 1;

  logic [SW-1:0] size_mem [NBLK];
  logic [LW-1:0] next_mem [NBLK];
  logic [LW-1:0] prev_mem [NBLK];

  // write ports
  always_ff @(posedge clk) begin
    if (we.size_we) size_mem[size_waddr] <= size_wdata;
    if (we.next_we) next_mem[next_waddr] <= next_wdata;
    if (we.prev_we) prev_mem[prev_waddr] <= prev_wdata;
  end

  // registered read, one shared address
  always_ff @(posedge clk) begin
    size_rdata <= size_mem[raddr];
    next_rdata <= next_mem[raddr];
    prev_rdata <= prev_mem[raddr];
  end

endmodule

/* rtl/tlsf_class_store.sv */
// Class store: list head memory, level bitmaps and the class search.
// Depends on tlsf_pkg.
module tlsf_class_store #(
  parameter int HEAP_BYTES   = 65536,
  parameter int FIRST_LEVELS = 19
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tlsf_pkg::cls_op_t                   op,
  input  logic [$clog2(FIRST_LEVELS*8)-1:0]   head_raddr,
  input  logic [$clog2(FIRST_LEVELS*8)-1:0]   head_waddr,
  input  logic [$clog2(HEAP_BYTES/16):0]      head_wdata,
  output logic [$clog2(HEAP_BYTES/16):0]      head_rdata,
  input  tlsf_pkg::cls_t                      map_cls,
  input  tlsf_pkg::cls_t                      find_q,
  output logic                                find_ok,
  output tlsf_pkg::cls_t                      find_cls
);
  import tlsf_pkg::*;

  localparam int NCLASS = FIRST_LEVELS * 8;
  localparam int LW     = $clog2(HEAP_BYTES/16) + 1;
  localparam int FIW    = $clog2(FIRST_LEVELS);
  localparam cls_t HCLS = classify(32'(HEAP_BYTES - 16), FIRST_LEVELS);
  localparam logic [FIRST_LEVELS-1:0] L1_INIT = FIRST_LEVELS'(1) << HCLS.f[FIW-1:0];

  logic [LW-1:0]           heads_mem [NCLASS];
  logic [FIRST_LEVELS-1:0] l1_r, l1_nxt;
  logic [7:0]              l2_r   [FIRST_LEVELS];
  logic [7:0]              l2_nxt [FIRST_LEVELS];

  // head memory
  always_ff @(posedge clk) begin
    if (op.head_we) heads_mem[head_waddr] <= head_wdata;
    head_rdata <= heads_mem[head_raddr];
  end

  // bitmap set on push, clear on emptied class
  always_comb begin
    logic [7:0] bit_s;
    logic [7:0] cleared;
    bit_s   = 8'd1 << map_cls.s;
    cleared = l2_r[map_cls.f[FIW-1:0]] & ~bit_s;
    l1_nxt  = l1_r;
    for (int k = 0; k < FIRST_LEVELS; k++) l2_nxt[k] = l2_r[k];
    if (op.map_set) begin
      l2_nxt[map_cls.f[FIW-1:0]] = l2_r[map_cls.f[FIW-1:0]] | bit_s;
      l1_nxt[map_cls.f[FIW-1:0]] = 1'b1;
    end else if (op.map_clr) begin
      l2_nxt[map_cls.f[FIW-1:0]] = cleared;
      if (cleared == 8'd0) l1_nxt[map_cls.f[FIW-1:0]] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= L1_INIT;
      for (int k = 0; k < FIRST_LEVELS; k++) begin
        l2_r[k] <= (k == int'(HCLS.f)) ? (8'd1 << HCLS.s) : 8'd0;
      end
    end else begin
      l1_r <= l1_nxt;
      for (int k = 0; k < FIRST_LEVELS; k++) l2_r[k] <= l2_nxt[k];
    end
  end

  // find the first non-empty class at or above the query
  always_comb begin
    logic [7:0]              sm;
    logic [7:0]              sm2;
    logic [FIRST_LEVELS-1:0] fm;
    logic [4:0]              fl;
    logic [4:0]              sl;
    sm = l2_r[find_q.f[FIW-1:0]] & (8'hFF << find_q.s);
    for (int k = 0; k < FIRST_LEVELS; k++) begin
      fm[k] = l1_r[k] && (5'(k) > find_q.f);
    end
    fl  = low_bit(32'(fm));
    sm2 = l2_r[fl[FIW-1:0]];
    find_ok  = 1'b0;
    find_cls = find_q;
    if (sm != 8'd0) begin
      sl = low_bit(32'(sm));
      find_ok    = 1'b1;
      find_cls.s = sl[2:0];
    end else begin
      sl = low_bit(32'(sm2));
      find_ok    = (fm != '0) && (sm2 != 8'd0);
      find_cls.f = fl;
      find_cls.s = sl[2:0];
    end
  end

endmodule

/* rtl/tlsf_chk.sv */
// Port-level checker for the TLSF allocator, bound to the top level.
// Depends on tlsf_pkg and tlsf_heap_allocator_unit_defines.svh.
`include "tlsf_heap_allocator_unit_defines.svh"
module tlsf_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_granted_addr
);
  import tlsf_pkg::*;

  // hold a stalled result
  `TLSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  // status stays within its codes
  `TLSF_ASSERT_NOW(a_status_code, out_valid, out_status <= STAT_IGN)

  // only a granted allocate carries an address
  `TLSF_ASSERT_NOW(a_addr_zero, out_valid && out_status != STAT_DONE, out_granted_addr == 32'd0)

  // one transaction in flight: busy right after an accept
  `TLSF_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)

endmodule

bind tlsf_heap_allocator_unit tlsf_chk u_tlsf_chk (.*);
